// File: hw/rtl/ght_pkg.sv
// shared types and constants for the generational handle table
// no dependencies; imported by every module of the block except ght_ram
`default_nettype none

package ght_pkg;

   // table geometry
   localparam int SLOTS   = 256;
   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int COUNT_W = $clog2(SLOTS + 1);
   localparam int ID_W    = 10;
   localparam int GEN_W   = 8;

   // command codes
   typedef enum logic [1:0] {
      CMD_CREATE  = 2'd0,
      CMD_LOOKUP  = 2'd1,
      CMD_DESTROY = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_STALE    = 2'd2,
      STATUS_NOT_LIVE = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_POP  = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   // free stack control and status
   typedef struct packed {
      logic              pop;
      logic              push;
      logic [SLOT_W-1:0] push_id;
   } stack_ctl_type;

   typedef struct packed {
      logic              empty;
      logic [SLOT_W-1:0] top_id;
   } stack_stat_type;

   // slot table write port
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [GEN_W-1:0]  gen;
      logic              live;
   } slot_wr_type;

endpackage

`default_nettype wire

// File: hw/rtl/generational_handle_table_unit.sv
// generational handle table: create, lookup and destroy of slot handles
// depends on ght_pkg, ght_free_stack, ght_slot_table (and ght_ram below them)
//
// order: accept, execute state, registered rsp_strobe for lookup, destroy and a refused
//   create; a popping create adds the pop state (stack ram read, then slot ram read)
// a new item is taken only while idle; busy drops in the strobe cycle
// reset: synchronous; no clearing pass, start is taken in the first cycle after reset
// results cannot be stalled by the receiver
`default_nettype none

module generational_handle_table_unit
   import ght_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [1:0]        req_cmd,
   input  wire logic [ID_W-1:0]   req_slot_id,
   input  wire logic [GEN_W-1:0]  req_generation,
   output logic                   rsp_strobe,
   output logic      [1:0]        rsp_status,
   output logic      [ID_W-1:0]   rsp_handle_id,
   output logic      [GEN_W-1:0]  rsp_handle_generation
);

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [ID_W-1:0]    sid_ff, sid_in;
   logic [GEN_W-1:0]   gen_ff, gen_in;
   logic               popped_ff, popped_in;
   logic [SLOT_W-1:0]  id_ff, id_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [GEN_W-1:0]   rsp_gen_ff, rsp_gen_in;

   stack_ctl_type      stack_ctl;
   stack_stat_type     stack_stat;
   slot_wr_type        slot_wr;
   logic               slot_rd_en;
   logic [SLOT_W-1:0]  slot_rd_addr;
   logic [GEN_W-1:0]   slot_gen;
   logic               slot_live;
   logic               accept;
   logic               in_range;
   logic [GEN_W-1:0]   next_gen;

   assign accept   = start && (state_ff == ST_IDLE);
   assign in_range = ({1'b0, sid_ff} < (ID_W + 1)'(SLOTS));
   assign next_gen = slot_gen + GEN_W'(1);

   // sequencer: accept, optional stack pop, slot read, write on an ok create or destroy
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sid_in        = sid_ff;
      gen_in        = gen_ff;
      popped_in     = popped_ff;
      id_in         = id_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_gen_in    = rsp_gen_ff;
      stack_ctl     = '0;
      slot_wr       = '0;
      slot_rd_en    = 1'b0;
      slot_rd_addr  = req_slot_id[SLOT_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = cmd_type'(req_cmd);
               sid_in    = req_slot_id;
               gen_in    = req_generation;
               popped_in = 1'b0;
               if (cmd_type'(req_cmd) == CMD_CREATE) begin
                  if (!stack_stat.empty) begin
                     stack_ctl.pop = 1'b1;
                     popped_in     = 1'b1;
                     state_in      = ST_POP;
                  end else begin
                     state_in = ST_EXEC;
                  end
               end else begin
                  slot_rd_en = 1'b1;
                  state_in   = ST_EXEC;
               end
            end
         end
         ST_POP: begin
            // popped id is ready, fetch its slot
            id_in        = stack_stat.top_id;
            slot_rd_en   = 1'b1;
            slot_rd_addr = stack_stat.top_id;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            rsp_strobe_in = 1'b1;
            rsp_gen_in    = '0;
            rsp_id_in     = sid_ff;
            state_in      = ST_IDLE;
            unique case (cmd_ff)
               CMD_CREATE: begin
                  if (popped_ff) begin
                     slot_wr.en    = 1'b1;
                     slot_wr.addr  = id_ff;
                     slot_wr.gen   = next_gen;
                     slot_wr.live  = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_id_in     = ID_W'(id_ff);
                     rsp_gen_in    = next_gen;
                  end else begin
                     rsp_status_in = STATUS_FULL;
                     rsp_id_in     = '0;
                  end
               end
               CMD_LOOKUP: begin
                  if (in_range && slot_live && (slot_gen == gen_ff)) begin
                     rsp_status_in = STATUS_OK;
                  end else begin
                     rsp_status_in = STATUS_STALE;
                  end
               end
               CMD_DESTROY: begin
                  if (in_range && slot_live) begin
                     slot_wr.en        = 1'b1;
                     slot_wr.addr      = sid_ff[SLOT_W-1:0];
                     slot_wr.gen       = slot_gen;
                     slot_wr.live      = 1'b0;
                     stack_ctl.push    = 1'b1;
                     stack_ctl.push_id = sid_ff[SLOT_W-1:0];
                     rsp_status_in     = STATUS_OK;
                  end else begin
                     rsp_status_in = STATUS_NOT_LIVE;
                  end
               end
               default: begin
                  rsp_status_in = STATUS_STALE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         popped_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         popped_ff     <= popped_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      sid_ff        <= sid_in;
      gen_ff        <= gen_in;
      id_ff         <= id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_gen_ff    <= rsp_gen_in;
   end

   ght_free_stack u_free_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stack_ctl),
      .stat  (stack_stat)
   );

   ght_slot_table u_slot_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_rd_addr),
      .wr      (slot_wr),
      .rd_gen  (slot_gen),
      .rd_live (slot_live)
   );

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_handle_id         = rsp_id_ff;
   assign rsp_handle_generation = rsp_gen_ff;

   // checks
   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_EXEC))
      else $error("result strobe without an execute cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_gen_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STATUS_OK)) |-> (rsp_handle_generation == '0))
      else $error("nonzero generation on a failed item");

endmodule

`default_nettype wire

// File: hw/rtl/ght_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ght_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ght_free_stack.sv
// lifo stack of free slot ids held in a ram
// depends on ght_pkg and ght_ram
`default_nettype none

module ght_free_stack
   import ght_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire stack_ctl_type  ctl,
   output stack_stat_type      stat
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] low_ff, low_in;
   logic               hit_ff, hit_in;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0] top_idx;
   logic               can_push;
   logic [SLOT_W-1:0]  ram_q;

   // positions below the low-water mark were never written and still hold their index
   assign top_idx  = count_ff - COUNT_W'(1);
   assign can_push = ctl.push && (count_ff < COUNT_W'(SLOTS));

   // count, low-water mark and pop bookkeeping
   always_comb begin
      count_in = count_ff;
      low_in   = low_ff;
      hit_in   = hit_ff;
      idx_in   = idx_ff;
      if (ctl.pop) begin
         count_in = top_idx;
         low_in   = (top_idx < low_ff) ? top_idx : low_ff;
         hit_in   = (top_idx >= low_ff);
         idx_in   = top_idx[SLOT_W-1:0];
      end else if (can_push) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(SLOTS);
         low_ff   <= COUNT_W'(SLOTS);
         hit_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         low_ff   <= low_in;
         hit_ff   <= hit_in;
         idx_ff   <= idx_in;
      end
   end

   // id storage
   ght_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (can_push),
      .wr_addr (count_ff[SLOT_W-1:0]),
      .wr_data (ctl.push_id),
      .rd_en   (ctl.pop),
      .rd_addr (top_idx[SLOT_W-1:0]),
      .rd_data (ram_q)
   );

   assign stat.empty  = (count_ff == '0);
   assign stat.top_id = hit_ff ? ram_q : idx_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(SLOTS))
      else $error("free stack count above slot count");

   a_low_water: assert property (@(posedge clock) disable iff (reset)
      low_ff <= count_ff)
      else $error("low-water mark above stack count");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> !stat.empty)
      else $error("pop from empty free stack");

endmodule

`default_nettype wire

// File: hw/rtl/ght_slot_table.sv
// per-slot generation and live bit in a ram, with written flags for reset state
// depends on ght_pkg and ght_ram
`default_nettype none

module ght_slot_table
   import ght_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [SLOT_W-1:0] rd_addr,
   input  wire slot_wr_type       wr,
   output logic      [GEN_W-1:0]  rd_gen,
   output logic                   rd_live
);

   logic [SLOTS-1:0] written_ff;
   logic             rd_written_ff;
   logic [GEN_W:0]   ram_q;

   // an entry never written reads as generation zero, not live
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            written_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   ght_ram #(
      .WIDTH (GEN_W + 1),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data ({wr.live, wr.gen}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rd_gen  = rd_written_ff ? ram_q[GEN_W-1:0] : '0;
   assign rd_live = rd_written_ff & ram_q[GEN_W];

endmodule

`default_nettype wire

// File: sim/tb.sv
// self-checking testbench for generational_handle_table_unit: directed rows, then random phases
// depends on ght_pkg and the handle table rtl; holds its own model of the slot table
`timescale 1ns / 1ps

module tb;
   import ght_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DIR_ROWS    = 24;

   typedef struct packed {
      cmd_type          cmd;
      logic [ID_W-1:0]  slot;
      logic [GEN_W-1:0] gen;
   } handle_request_type;

   typedef struct packed {
      status_type       status;
      logic [ID_W-1:0]  id;
      logic [GEN_W-1:0] gen;
   } handle_result_type;

   typedef struct packed {
      logic             typed;
      cmd_type          cmd;
      logic [ID_W-1:0]  slot;
      logic [GEN_W-1:0] gen;
      status_type       exp_status;
      logic [ID_W-1:0]  exp_id;
      logic [GEN_W-1:0] exp_gen;
   } directed_row_type;

   typedef enum int {MODE_MIXED, MODE_FILL, MODE_DRAIN, MODE_CHURN} mode_type;

   // directed rows from reset; the last one is left to the model
   localparam directed_row_type DIRECTED [DIR_ROWS] = '{
      '{1'b1, CMD_CREATE,  10'd0,    8'd0,   STATUS_OK,       10'd255,  8'd1},
      '{1'b1, CMD_CREATE,  10'd0,    8'd0,   STATUS_OK,       10'd254,  8'd1},
      '{1'b1, CMD_LOOKUP,  10'd255,  8'd1,   STATUS_OK,       10'd255,  8'd0},
      '{1'b1, CMD_LOOKUP,  10'd255,  8'd0,   STATUS_STALE,    10'd255,  8'd0},
      '{1'b1, CMD_LOOKUP,  10'd254,  8'd255, STATUS_STALE,    10'd254,  8'd0},
      '{1'b1, CMD_LOOKUP,  10'd0,    8'd0,   STATUS_STALE,    10'd0,    8'd0},
      '{1'b1, CMD_LOOKUP,  10'd256,  8'd0,   STATUS_STALE,    10'd256,  8'd0},
      '{1'b1, CMD_LOOKUP,  10'd1023, 8'd255, STATUS_STALE,    10'd1023, 8'd0},
      '{1'b1, CMD_DESTROY, 10'd1023, 8'd0,   STATUS_NOT_LIVE, 10'd1023, 8'd0},
      '{1'b1, CMD_DESTROY, 10'd256,  8'd0,   STATUS_NOT_LIVE, 10'd256,  8'd0},
      '{1'b1, CMD_DESTROY, 10'd0,    8'd0,   STATUS_NOT_LIVE, 10'd0,    8'd0},
      '{1'b1, CMD_UNUSED,  10'd1023, 8'd255, STATUS_STALE,    10'd1023, 8'd0},
      '{1'b1, CMD_UNUSED,  10'd255,  8'd1,   STATUS_STALE,    10'd255,  8'd0},
      '{1'b1, CMD_DESTROY, 10'd255,  8'd0,   STATUS_OK,       10'd255,  8'd0},
      '{1'b1, CMD_LOOKUP,  10'd255,  8'd1,   STATUS_STALE,    10'd255,  8'd0},
      '{1'b1, CMD_DESTROY, 10'd255,  8'd0,   STATUS_NOT_LIVE, 10'd255,  8'd0},
      '{1'b1, CMD_CREATE,  10'd0,    8'd0,   STATUS_OK,       10'd255,  8'd2},
      '{1'b1, CMD_DESTROY, 10'd254,  8'd0,   STATUS_OK,       10'd254,  8'd0},
      '{1'b1, CMD_DESTROY, 10'd255,  8'd0,   STATUS_OK,       10'd255,  8'd0},
      '{1'b1, CMD_CREATE,  10'd0,    8'd0,   STATUS_OK,       10'd255,  8'd3},
      '{1'b1, CMD_CREATE,  10'd0,    8'd0,   STATUS_OK,       10'd254,  8'd2},
      '{1'b1, CMD_LOOKUP,  10'd254,  8'd2,   STATUS_OK,       10'd254,  8'd0},
      '{1'b1, CMD_LOOKUP,  10'd682,  8'd85,  STATUS_STALE,    10'd682,  8'd0},
      '{1'b0, CMD_CREATE,  10'd1023, 8'd255, STATUS_OK,       10'd0,    8'd0}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [1:0]       req_cmd = '0;
   logic [ID_W-1:0]  req_slot_id = '0;
   logic [GEN_W-1:0] req_generation = '0;
   logic             rsp_strobe;
   logic [1:0]       rsp_status;
   logic [ID_W-1:0]  rsp_handle_id;
   logic [GEN_W-1:0] rsp_handle_generation;

   // model of the table
   logic [ID_W-1:0]  model_stack [SLOTS];
   int               free_count;
   logic [GEN_W-1:0] slot_gen [SLOTS];
   logic             slot_is_live [SLOTS];

   handle_result_type pending_results [$];
   int                mismatches = 0;
   int                cycle_count = 0;
   int                last_created = -1;
   logic              no_gaps = 1'b0;

   generational_handle_table_unit u_top (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_cmd               (req_cmd),
      .req_slot_id           (req_slot_id),
      .req_generation        (req_generation),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_handle_id         (rsp_handle_id),
      .rsp_handle_generation (rsp_handle_generation)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // advance the table model by one command
   task automatic apply_command(input handle_request_type req, output handle_result_type res);
      logic [ID_W-1:0] id;
      res = '{STATUS_STALE, req.slot, '0};
      case (req.cmd)
         CMD_CREATE: begin
            if (free_count == 0) begin
               res = '{STATUS_FULL, '0, '0};
            end else begin
               free_count--;
               id = model_stack[free_count];
               if (id >= SLOTS) begin
                  res = '{STATUS_FULL, '0, '0};
               end else begin
                  slot_gen[id]     = slot_gen[id] + 1'b1;
                  slot_is_live[id] = 1'b1;
                  res = '{STATUS_OK, id, slot_gen[id]};
               end
            end
         end
         CMD_LOOKUP: begin
            if (req.slot < SLOTS && slot_is_live[req.slot] && slot_gen[req.slot] == req.gen)
               res.status = STATUS_OK;
         end
         CMD_DESTROY: begin
            if (req.slot >= SLOTS || !slot_is_live[req.slot]) begin
               res.status = STATUS_NOT_LIVE;
            end else begin
               slot_is_live[req.slot] = 1'b0;
               if (free_count < SLOTS) begin
                  model_stack[free_count] = req.slot;
                  free_count++;
               end
               res.status = STATUS_OK;
            end
         end
         default: ;
      endcase
   endtask

   // a live slot picked from a random place, or -1 when none is live
   function automatic int find_live();
      int base;
      int n;
      base = $urandom_range(0, SLOTS - 1);
      for (n = 0; n < SLOTS; n++)
         if (slot_is_live[(base + n) % SLOTS])
            return (base + n) % SLOTS;
      return -1;
   endfunction

   // random command shaped by the phase
   function automatic handle_request_type pick_request(input mode_type mode);
      handle_request_type req;
      int roll;
      int live_id;
      req.cmd  = CMD_CREATE;
      req.slot = ID_W'($urandom_range(0, 1023));
      req.gen  = GEN_W'($urandom);
      roll     = $urandom_range(0, 99);
      // churn keeps recycling the same slot so its generation wraps
      if (mode == MODE_CHURN) begin
         if (last_created >= 0 && slot_is_live[last_created]) begin
            req.cmd  = (roll < 5) ? CMD_LOOKUP : CMD_DESTROY;
            req.slot = ID_W'(last_created);
            req.gen  = slot_gen[last_created];
         end
         return req;
      end
      if (mode == MODE_FILL)
         roll = (roll < 85) ? 0 : $urandom_range(30, 99);
      else if (mode == MODE_DRAIN)
         roll = (roll < 70) ? 70 : $urandom_range(0, 99);
      live_id = find_live();
      if (roll < 30 || (live_id < 0 && (roll < 58 || (roll >= 68 && roll < 85))))
         return req;
      if (roll < 58) begin
         req.cmd  = CMD_LOOKUP;
         req.slot = ID_W'(live_id);
         req.gen  = slot_gen[live_id];
         if (roll >= 50)
            req.gen = slot_gen[live_id] + GEN_W'($urandom_range(1, 255));
      end else if (roll < 68) begin
         req.cmd = CMD_LOOKUP;
      end else if (roll < 85) begin
         req.cmd  = CMD_DESTROY;
         req.slot = ID_W'(live_id);
      end else if (roll < 93) begin
         req.cmd = CMD_DESTROY;
      end else begin
         req.cmd = CMD_UNUSED;
      end
      return req;
   endfunction

   // offer one item after an optional random gap, wait until busy drops, record its expected result
   task automatic send_command(input handle_request_type req, input logic use_typed,
                               input handle_result_type typed_res,
                               output handle_result_type pred);
      int gap;
      gap = 0;
      if (!no_gaps) begin
         if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(5, 30);
         else if ($urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= req.cmd;
      req_slot_id    <= req.slot;
      req_generation <= req.gen;
      do @(posedge clock); while (busy);
      apply_command(req, pred);
      pending_results.push_back(use_typed ? typed_res : pred);
   endtask

   task automatic run_phase(input mode_type mode, input int count);
      handle_request_type req;
      handle_result_type  pred;
      int full_hits;
      int k;
      full_hits = 0;
      no_gaps   = ($urandom_range(0, 3) == 0);
      for (k = 0; k < count; k++) begin
         req = pick_request(mode);
         send_command(req, 1'b0, '0, pred);
         if (req.cmd == CMD_CREATE && pred.status == STATUS_OK)
            last_created = pred.id;
         if (pred.status == STATUS_FULL)
            full_hits++;
         // a fill phase ends early once the empty stack has been hit four times
         if (mode == MODE_FILL && full_hits >= 4)
            break;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      handle_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d id %0d generation %0d",
                   rsp_status, rsp_handle_id, rsp_handle_generation);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_handle_id !== want.id) begin
               $error("rsp_handle_id: expected %0d, got %0d", want.id, rsp_handle_id);
               mismatches++;
            end
            if (rsp_handle_generation !== want.gen) begin
               $error("rsp_handle_generation: expected %0d, got %0d",
                      want.gen, rsp_handle_generation);
               mismatches++;
            end
         end
      end
   end

   // main sequence
   initial begin
      handle_request_type req;
      handle_result_type  typed_res;
      handle_result_type  pred;
      int i;
      for (i = 0; i < SLOTS; i++) begin
         model_stack[i]  = ID_W'(i);
         slot_gen[i]     = '0;
         slot_is_live[i] = 1'b0;
      end
      free_count = SLOTS;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      for (i = 0; i < DIR_ROWS; i++) begin
         req       = '{DIRECTED[i].cmd, DIRECTED[i].slot, DIRECTED[i].gen};
         typed_res = '{DIRECTED[i].exp_status, DIRECTED[i].exp_id, DIRECTED[i].exp_gen};
         send_command(req, DIRECTED[i].typed, typed_res, pred);
      end

      // random phases: mixed, fill to empty stack, drain, recycle one slot past a wrap, mixed
      run_phase(MODE_MIXED, 20);
      run_phase(MODE_FILL, 400);
      run_phase(MODE_DRAIN, 40);
      run_phase(MODE_CHURN, 560);
      run_phase(MODE_MIXED, 10);
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/ght_pkg.sv
hw/rtl/ght_ram.sv
hw/rtl/ght_free_stack.sv
hw/rtl/ght_slot_table.sv
hw/rtl/generational_handle_table_unit.sv
sim/tb.sv
